// ----- src/cpec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cpec_pkg;

    localparam int FRONT_LAT = 5;
    localparam int SQRT_LAT  = 32;
    localparam int DIV_LAT   = 31;
    localparam int BACK_LAT  = 10;
    localparam int N_PRD     = 10;

    localparam int Q_N = 30;
    localparam int Q_K = 29;
    localparam int Q_B = 15;

    localparam logic [15:0] BOUNCE_ONE = 16'd32768;

    typedef logic signed [36:0] t_val;
    typedef logic signed [31:0] t_fac;

    localparam t_fac FAC_ONE  = 32'sd1073741824;
    localparam t_fac FAC_HALF = 32'sd536870912;
    localparam t_val VAL_MAX  = 37'sd2147483647;
    localparam t_val VAL_MIN  = -37'sd2147483648;

    typedef struct packed {
        logic [63:0] mag;
        logic        neg;
    } t_prd;

    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic [30:0]        rad;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
        logic signed [31:0] bvx;
        logic signed [31:0] bvy;
        logic [31:0]        mb;
        logic [15:0]        ab;
        logic [15:0]        bb;
        logic [31:0]        mdx;
        logic [31:0]        mdy;
        logic [31:0]        m;
        logic [63:0]        sqx;
        logic [63:0]        sqy;
        logic [63:0]        r2;
        logic [63:0]        sum;
        logic [63:0]        nk;
        logic [32:0]        s;
        logic               hit;
        logic               zero;
        logic [4:0]         sh;
        logic [31:0]        smx;
        logic [31:0]        smy;
        t_fac               nx;
        t_fac               ny;
        t_fac               ka;
        t_fac               kb;
        t_fac               fa;
        t_fac               fb;
        t_prd [N_PRD-1:0]   p;
        t_val [N_PRD-1:0]   w;
        t_val               vna;
        t_val               vnb;
        t_val               vta;
        t_val               vtb;
        t_val               da;
        t_val               db;
        t_val               ra;
        t_val               rb;
        t_val               tba;
        t_val               tbb;
    } t_item;

    typedef struct packed {
        logic        collided;
        logic [31:0] new_offset_x;
        logic [31:0] new_offset_y;
        logic [31:0] new_a_vel_x;
        logic [31:0] new_a_vel_y;
        logic [31:0] new_b_vel_x;
        logic [31:0] new_b_vel_y;
    } t_res;

    function automatic logic [31:0] f_abs32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    function automatic logic [63:0] f_sq32(input logic [31:0] x);
        return {32'b0, x} * {32'b0, x};
    endfunction

    function automatic t_val f_ext(input logic signed [31:0] x);
        return {{5{x[31]}}, x};
    endfunction

    function automatic t_prd f_mul(input t_val a, input t_fac b);
        logic [36:0] am;
        logic [31:0] bm;
        logic [68:0] pr;
        t_prd        r;
        am = a[36] ? 37'(-a) : 37'(a);
        bm = b[31] ? 32'(-b) : 32'(b);
        pr = {32'b0, am} * {37'b0, bm};
        r.mag = pr[63:0];
        r.neg = a[36] ^ b[31];
        return r;
    endfunction

    // round to nearest, halves away from zero
    function automatic t_val f_rnd(input t_prd p, input int k);
        logic [64:0] s;
        s = {1'b0, p.mag} + (65'd1 << (k - 1));
        s = s >> k;
        return p.neg ? -$signed(s[36:0]) : $signed(s[36:0]);
    endfunction

    function automatic logic [31:0] f_sat(input t_val v);
        if (v > VAL_MAX) begin
            return 32'h7FFF_FFFF;
        end else if (v < VAL_MIN) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/cpec_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cpec_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic [30:0]        combined_radius;
    logic signed [31:0] a_vel_x;
    logic signed [31:0] a_vel_y;
    logic signed [31:0] b_vel_x;
    logic signed [31:0] b_vel_y;
    logic [31:0]        a_mass;
    logic [31:0]        b_mass;
    logic [15:0]        a_bounce;
    logic [15:0]        b_bounce;

    modport source (
        output valid, offset_x, offset_y, combined_radius, a_vel_x, a_vel_y,
               b_vel_x, b_vel_y, a_mass, b_mass, a_bounce, b_bounce,
        input  ready
    );
    modport sink (
        input  valid, offset_x, offset_y, combined_radius, a_vel_x, a_vel_y,
               b_vel_x, b_vel_y, a_mass, b_mass, a_bounce, b_bounce,
        output ready
    );
endinterface

interface cpec_out_if;
    logic               valid;
    logic               ready;
    logic               collided;
    logic signed [31:0] new_offset_x;
    logic signed [31:0] new_offset_y;
    logic signed [31:0] new_a_vel_x;
    logic signed [31:0] new_a_vel_y;
    logic signed [31:0] new_b_vel_x;
    logic signed [31:0] new_b_vel_y;

    modport source (
        output valid, collided, new_offset_x, new_offset_y, new_a_vel_x,
               new_a_vel_y, new_b_vel_x, new_b_vel_y,
        input  ready
    );
    modport sink (
        input  valid, collided, new_offset_x, new_offset_y, new_a_vel_x,
               new_a_vel_y, new_b_vel_x, new_b_vel_y,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/circle_pair_elastic_collision_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Resolves one circle pair per clock while results are taken: a new pair transfer can be taken
// in every such cycle and results leave in input order. The pipeline depth is set by the
// 32-step pipelined square root of the normalized offset length and the 31-step pipelined
// dividers that form the unit normal and the mass ratio; products and roundings around them
// take one stage each. While a finished result is not taken the whole pipeline holds.

module circle_pair_elastic_collision_top import cpec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpec_in_if.sink    i_pair,
    cpec_out_if.source o_res
);

    logic w_en;

    logic [FRONT_LAT-1:0] r_vf;
    logic [SQRT_LAT-1:0]  r_vq;
    logic [DIV_LAT-1:0]   r_vd;
    logic [BACK_LAT-1:0]  r_vb;
    logic                 r_vo;

    t_item r_f [FRONT_LAT];
    t_item n_f [FRONT_LAT];
    t_item r_q [SQRT_LAT];
    t_item r_d [DIV_LAT];
    t_item r_b [BACK_LAT];
    t_item n_b [BACK_LAT];
    t_res  r_o;
    t_res  n_o;

    logic [31:0] w_len;
    logic [63:0] w_num_x;
    logic [63:0] w_num_y;
    logic [32:0] w_den_n;
    logic [30:0] w_qx;
    logic [30:0] w_qy;
    logic [30:0] w_qk;
    logic [4:0]  w_msb;

    assign w_en         = !r_vo || o_res.ready;
    assign i_pair.ready = w_en;

    // front: overlap test and offset normalization
    always_comb begin
        w_msb = '0;

        n_f[0]       = '0;
        n_f[0].dx    = i_pair.offset_x;
        n_f[0].dy    = i_pair.offset_y;
        n_f[0].rad   = i_pair.combined_radius;
        n_f[0].avx   = i_pair.a_vel_x;
        n_f[0].avy   = i_pair.a_vel_y;
        n_f[0].bvx   = i_pair.b_vel_x;
        n_f[0].bvy   = i_pair.b_vel_y;
        n_f[0].mb    = i_pair.b_mass;
        n_f[0].ab    = i_pair.a_bounce;
        n_f[0].bb    = i_pair.b_bounce;
        n_f[0].mdx   = f_abs32(i_pair.offset_x);
        n_f[0].mdy   = f_abs32(i_pair.offset_y);
        n_f[0].m     = (n_f[0].mdx > n_f[0].mdy) ? n_f[0].mdx : n_f[0].mdy;
        n_f[0].sqx   = f_sq32(n_f[0].mdx);
        n_f[0].sqy   = f_sq32(n_f[0].mdy);
        n_f[0].r2    = f_sq32({1'b0, i_pair.combined_radius});
        n_f[0].s     = {1'b0, i_pair.a_mass} + {1'b0, i_pair.b_mass};

        n_f[1]       = r_f[0];
        n_f[1].hit   = (r_f[0].sqx + r_f[0].sqy) < r_f[0].r2;
        n_f[1].zero  = (r_f[0].dx == '0) && (r_f[0].dy == '0);
        n_f[1].nk    = ({32'b0, r_f[0].mb} << Q_N) + {32'b0, r_f[0].s[32:1]};
        for (int i = 0; i < 31; i++) begin
            if (r_f[0].m[i]) begin
                w_msb = 5'(i);
            end
        end
        n_f[1].sh    = r_f[0].m[31] ? 5'd0 : 5'(5'd30 - w_msb);

        n_f[2]       = r_f[1];
        n_f[2].smx   = r_f[1].mdx << r_f[1].sh;
        n_f[2].smy   = r_f[1].mdy << r_f[1].sh;

        n_f[3]       = r_f[2];
        n_f[3].sqx   = f_sq32(r_f[2].smx);
        n_f[3].sqy   = f_sq32(r_f[2].smy);

        n_f[4]       = r_f[3];
        n_f[4].sum   = r_f[3].sqx + r_f[3].sqy;
    end

    cpec_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_f[FRONT_LAT-1].sum),
        .o_root (w_len)
    );

    assign w_num_x = ({32'b0, r_q[SQRT_LAT-1].smx} << Q_N) + {33'b0, w_len[31:1]};
    assign w_num_y = ({32'b0, r_q[SQRT_LAT-1].smy} << Q_N) + {33'b0, w_len[31:1]};
    assign w_den_n = {1'b0, w_len};

    cpec_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_num_x),
        .i_den  (w_den_n),
        .o_quot (w_qx)
    );

    cpec_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_num_y),
        .i_den  (w_den_n),
        .o_quot (w_qy)
    );

    cpec_div u_div_k (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_q[SQRT_LAT-1].nk),
        .i_den  (r_q[SQRT_LAT-1].s),
        .o_quot (w_qk)
    );

    // back: projections, normal exchange, tangent scaling, recombination
    always_comb begin
        n_b[0] = r_d[DIV_LAT-1];
        if (r_d[DIV_LAT-1].zero) begin
            n_b[0].nx = FAC_ONE;
            n_b[0].ny = '0;
        end else begin
            n_b[0].nx = r_d[DIV_LAT-1].dx[31] ? -t_fac'({1'b0, w_qx}) : t_fac'({1'b0, w_qx});
            n_b[0].ny = r_d[DIV_LAT-1].dy[31] ? -t_fac'({1'b0, w_qy}) : t_fac'({1'b0, w_qy});
        end
        n_b[0].kb = (r_d[DIV_LAT-1].s == '0) ? FAC_HALF : t_fac'({1'b0, w_qk});
        n_b[0].ka = FAC_ONE - n_b[0].kb;
        n_b[0].fa = (r_d[DIV_LAT-1].ab > BOUNCE_ONE) ? t_fac'({16'b0, BOUNCE_ONE})
                                                     : t_fac'({16'b0, r_d[DIV_LAT-1].ab});
        n_b[0].fb = (r_d[DIV_LAT-1].bb > BOUNCE_ONE) ? t_fac'({16'b0, BOUNCE_ONE})
                                                     : t_fac'({16'b0, r_d[DIV_LAT-1].bb});

        n_b[1]      = r_b[0];
        n_b[1].p[0] = f_mul(f_ext(r_b[0].avx), r_b[0].nx);
        n_b[1].p[1] = f_mul(f_ext(r_b[0].avy), r_b[0].ny);
        n_b[1].p[2] = f_mul(f_ext(r_b[0].bvx), r_b[0].nx);
        n_b[1].p[3] = f_mul(f_ext(r_b[0].bvy), r_b[0].ny);
        n_b[1].p[4] = f_mul(f_ext(r_b[0].avy), r_b[0].nx);
        n_b[1].p[5] = f_mul(f_ext(r_b[0].avx), r_b[0].ny);
        n_b[1].p[6] = f_mul(f_ext(r_b[0].bvy), r_b[0].nx);
        n_b[1].p[7] = f_mul(f_ext(r_b[0].bvx), r_b[0].ny);
        n_b[1].p[8] = f_mul(t_val'({6'b0, r_b[0].rad}), r_b[0].nx);
        n_b[1].p[9] = f_mul(t_val'({6'b0, r_b[0].rad}), r_b[0].ny);

        n_b[2] = r_b[1];
        for (int i = 0; i < N_PRD; i++) begin
            n_b[2].w[i] = f_rnd(r_b[1].p[i], Q_N);
        end

        n_b[3]     = r_b[2];
        n_b[3].vna = r_b[2].w[0] + r_b[2].w[1];
        n_b[3].vnb = r_b[2].w[2] + r_b[2].w[3];
        n_b[3].vta = r_b[2].w[4] - r_b[2].w[5];
        n_b[3].vtb = r_b[2].w[6] - r_b[2].w[7];

        n_b[4]    = r_b[3];
        n_b[4].da = r_b[3].vnb - r_b[3].vna;
        n_b[4].db = r_b[3].vna - r_b[3].vnb;

        n_b[5]      = r_b[4];
        n_b[5].p[0] = f_mul(r_b[4].vta, r_b[4].fa);
        n_b[5].p[1] = f_mul(r_b[4].vtb, r_b[4].fb);
        n_b[5].p[2] = f_mul(r_b[4].da, r_b[4].kb);
        n_b[5].p[3] = f_mul(r_b[4].db, r_b[4].ka);

        n_b[6]      = r_b[5];
        n_b[6].w[0] = f_rnd(r_b[5].p[0], Q_B);
        n_b[6].w[1] = f_rnd(r_b[5].p[1], Q_B);
        n_b[6].w[2] = f_rnd(r_b[5].p[2], Q_K);
        n_b[6].w[3] = f_rnd(r_b[5].p[3], Q_K);

        n_b[7]     = r_b[6];
        n_b[7].ra  = r_b[6].vna + r_b[6].w[2];
        n_b[7].rb  = r_b[6].vnb + r_b[6].w[3];
        n_b[7].tba = r_b[6].w[0];
        n_b[7].tbb = r_b[6].w[1];

        n_b[8]      = r_b[7];
        n_b[8].p[0] = f_mul(r_b[7].ra, r_b[7].nx);
        n_b[8].p[1] = f_mul(r_b[7].tba, r_b[7].ny);
        n_b[8].p[2] = f_mul(r_b[7].ra, r_b[7].ny);
        n_b[8].p[3] = f_mul(r_b[7].tba, r_b[7].nx);
        n_b[8].p[4] = f_mul(r_b[7].rb, r_b[7].nx);
        n_b[8].p[5] = f_mul(r_b[7].tbb, r_b[7].ny);
        n_b[8].p[6] = f_mul(r_b[7].rb, r_b[7].ny);
        n_b[8].p[7] = f_mul(r_b[7].tbb, r_b[7].nx);

        n_b[9] = r_b[8];
        for (int i = 0; i < 8; i++) begin
            n_b[9].w[i] = f_rnd(r_b[8].p[i], Q_N);
        end

        if (r_b[9].hit) begin
            n_o.collided     = 1'b1;
            n_o.new_offset_x = r_b[9].w[8][31:0];
            n_o.new_offset_y = r_b[9].w[9][31:0];
            n_o.new_a_vel_x  = f_sat(r_b[9].w[0] - r_b[9].w[1]);
            n_o.new_a_vel_y  = f_sat(r_b[9].w[2] + r_b[9].w[3]);
            n_o.new_b_vel_x  = f_sat(r_b[9].w[4] - r_b[9].w[5]);
            n_o.new_b_vel_y  = f_sat(r_b[9].w[6] + r_b[9].w[7]);
        end else begin
            n_o.collided     = 1'b0;
            n_o.new_offset_x = r_b[9].dx;
            n_o.new_offset_y = r_b[9].dy;
            n_o.new_a_vel_x  = r_b[9].avx;
            n_o.new_a_vel_y  = r_b[9].avy;
            n_o.new_b_vel_x  = r_b[9].bvx;
            n_o.new_b_vel_y  = r_b[9].bvy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f    <= n_f;
            r_q[0] <= r_f[FRONT_LAT-1];
            for (int k = 1; k < SQRT_LAT; k++) begin
                r_q[k] <= r_q[k-1];
            end
            r_d[0] <= r_q[SQRT_LAT-1];
            for (int k = 1; k < DIV_LAT; k++) begin
                r_d[k] <= r_d[k-1];
            end
            r_b <= n_b;
            r_o <= n_o;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= '0;
            r_vq <= '0;
            r_vd <= '0;
            r_vb <= '0;
            r_vo <= 1'b0;
        end else if (w_en) begin
            r_vf <= {r_vf[FRONT_LAT-2:0], i_pair.valid};
            r_vq <= {r_vq[SQRT_LAT-2:0], r_vf[FRONT_LAT-1]};
            r_vd <= {r_vd[DIV_LAT-2:0], r_vq[SQRT_LAT-1]};
            r_vb <= {r_vb[BACK_LAT-2:0], r_vd[DIV_LAT-1]};
            r_vo <= r_vb[BACK_LAT-1];
        end
    end

    assign o_res.valid        = r_vo;
    assign o_res.collided     = r_o.collided;
    assign o_res.new_offset_x = r_o.new_offset_x;
    assign o_res.new_offset_y = r_o.new_offset_y;
    assign o_res.new_a_vel_x  = r_o.new_a_vel_x;
    assign o_res.new_a_vel_y  = r_o.new_a_vel_y;
    assign o_res.new_b_vel_x  = r_o.new_b_vel_x;
    assign o_res.new_b_vel_y  = r_o.new_b_vel_y;

endmodule

`default_nettype wire

// ----- src/cpec_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cpec_sqrt import cpec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    logic [33:0] r_rem  [SQRT_LAT];
    logic [31:0] r_root [SQRT_LAT];
    logic [63:0] r_rad  [SQRT_LAT];

    for (genvar g = 0; g < SQRT_LAT; g++) begin : g_step
        logic [33:0] w_rem;
        logic [31:0] w_root;
        logic [63:0] w_rad;
        logic [35:0] w_sh;
        logic [35:0] w_trial;
        logic [33:0] n_rem;
        logic [31:0] n_root;

        if (g == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = i_rad;
        end else begin : g_next
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
            assign w_rad  = r_rad[g-1];
        end

        always_comb begin
            w_sh    = {w_rem, w_rad[63-2*g -: 2]};
            w_trial = {2'b00, w_root, 2'b01};
            if (w_sh >= w_trial) begin
                n_rem  = 34'(w_sh - w_trial);
                n_root = {w_root[30:0], 1'b1};
            end else begin
                n_rem  = w_sh[33:0];
                n_root = {w_root[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_rad[g]  <= w_rad;
            end
        end
    end

    assign o_root = r_root[SQRT_LAT-1];

endmodule

`default_nettype wire

// ----- src/cpec_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cpec_div import cpec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output logic [30:0] o_quot
);

    logic [32:0] r_rem  [DIV_LAT];
    logic [30:0] r_quot [DIV_LAT];
    logic [63:0] r_num  [DIV_LAT];
    logic [32:0] r_den  [DIV_LAT];

    for (genvar g = 0; g < DIV_LAT; g++) begin : g_step
        logic [32:0] w_rem;
        logic [30:0] w_quot;
        logic [63:0] w_num;
        logic [32:0] w_den;
        logic [33:0] w_sh;
        logic [32:0] n_rem;
        logic [30:0] n_quot;

        if (g == 0) begin : g_first
            assign w_rem  = i_num[63:31];
            assign w_quot = '0;
            assign w_num  = i_num;
            assign w_den  = i_den;
        end else begin : g_next
            assign w_rem  = r_rem[g-1];
            assign w_quot = r_quot[g-1];
            assign w_num  = r_num[g-1];
            assign w_den  = r_den[g-1];
        end

        always_comb begin
            w_sh   = {w_rem, w_num[DIV_LAT-1-g]};
            n_quot = w_quot;
            if (w_sh >= {1'b0, w_den}) begin
                n_rem                = 33'(w_sh - {1'b0, w_den});
                n_quot[DIV_LAT-1-g] = 1'b1;
            end else begin
                n_rem = w_sh[32:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_quot[g] <= n_quot;
                r_num[g]  <= w_num;
                r_den[g]  <= w_den;
            end
        end
    end

    assign o_quot = r_quot[DIV_LAT-1];

endmodule

`default_nettype wire

// ----- src/cpec_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cpec_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [192:0] i_out_data
);

    // output transfer held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("output payload changed while stalled");

    // whole pipe advances exactly when the output register can move
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow pipeline advance");

    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(i_in_valid))
        else $error("input valid unknown");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind circle_pair_elastic_collision_top cpec_checker u_cpec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pair.valid),
    .i_in_ready  (i_pair.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  ({o_res.collided, o_res.new_offset_x, o_res.new_offset_y,
                   o_res.new_a_vel_x, o_res.new_a_vel_y,
                   o_res.new_b_vel_x, o_res.new_b_vel_y})
);

`default_nettype wire
